// File: design/hbw_pkg.sv
// package for the heartbeat watchdog: channel count, opcodes and widths
// no dependencies; used by multi_task_heartbeat_watchdog, hbw_checker and the testbench top
package hbw_pkg;

   localparam int NUM_TASKS = 8;
   localparam int TASK_IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int ID_W = 4;
   localparam int TIME_W = 32;
   localparam int MASK_W = 8;
   localparam int CHAN_W = 3;

   localparam logic [TASK_IDX_W-1:0] LAST_TASK = TASK_IDX_W'(NUM_TASKS - 1);
   localparam logic [ID_W:0] TASK_LIMIT = (ID_W + 1)'(NUM_TASKS);
   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd3000;

   typedef enum logic [1:0] {
      OP_REGISTER  = 2'd0,
      OP_HEARTBEAT = 2'd1,
      OP_CHECK     = 2'd2
   } op_type;

endpackage

// File: design/hbw_time_ram.sv
// last-seen timestamp store: one write port, one read port, registered read data
// generic; no package dependency
module hbw_time_ram #(
   parameter int DEPTH = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/multi_task_heartbeat_watchdog.sv
// heartbeat watchdog top level: request decode, scan sequencer, flags and result
// depends on hbw_pkg and hbw_time_ram
//
//   channel   ports                       handshake
//   request   start, busy, req_*          taken when start high and busy low
//   result    rsp_valid, rsp_*            one-cycle strobe, cannot be held off
//   csr       csr_wr_en, csr_wr_data      timeout_ms written when csr_wr_en high
//
// register, heartbeat and unknown opcodes leave the sequencer idle; the result shows in the
// next cycle and another request may be taken in that same cycle.
// a check reads one last-seen entry per cycle from the timestamp ram in SCAN, then goes
// through DRAIN: busy is high in SCAN and DRAIN and the result is registered out of DRAIN.
// synchronous reset clears all flags, the counter and sets timeout_ms to 3000; the
// timestamp ram is not cleared, since only registered channels are ever compared.
module multi_task_heartbeat_watchdog (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_operation,
   input  logic [hbw_pkg::ID_W-1:0]     req_task_id,
   input  logic [hbw_pkg::TIME_W-1:0]   req_time_ms,
   input  logic                         csr_wr_en,
   input  logic [hbw_pkg::TIME_W-1:0]   csr_wr_data,
   output logic                         rsp_valid,
   output logic [hbw_pkg::MASK_W-1:0]   rsp_timed_out_mask,
   output logic                         rsp_any_timed_out,
   output logic [hbw_pkg::CHAN_W-1:0]   rsp_last_timed_out_channel,
   output logic [hbw_pkg::TIME_W-1:0]   rsp_total_timeouts,
   output logic                         rsp_timeout_event,
   output logic                         rsp_recovered
);

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      DRAIN
   } state_type;

   state_type state_ff, state_in;

   logic [hbw_pkg::TIME_W-1:0]     timeout_ff, timeout_in;
   logic [hbw_pkg::TIME_W-1:0]     now_ff, now_in;
   logic [hbw_pkg::NUM_TASKS-1:0]  registered_ff, registered_in;
   logic [hbw_pkg::NUM_TASKS-1:0]  timed_out_ff, timed_out_in;
   logic [hbw_pkg::TASK_IDX_W-1:0] idx_ff, idx_in;
   logic [hbw_pkg::TASK_IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic                           cmp_valid_ff, cmp_valid_in;
   logic                           any_ff, any_in;
   logic [hbw_pkg::CHAN_W-1:0]     last_ff, last_in;
   logic [hbw_pkg::TIME_W-1:0]     count_ff, count_in;
   logic                           event_ff, event_in;
   logic                           recov_ff, recov_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic                           accept;
   logic                           id_ok;
   logic [hbw_pkg::TASK_IDX_W-1:0] req_idx;
   logic                           ram_we;
   logic [hbw_pkg::TIME_W-1:0]     ram_rd_data;
   logic [hbw_pkg::TIME_W-1:0]     elapsed;
   logic                           hit;

   hbw_time_ram #(
      .DEPTH  (hbw_pkg::NUM_TASKS),
      .ADDR_W (hbw_pkg::TASK_IDX_W),
      .DATA_W (hbw_pkg::TIME_W)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_idx),
      .wr_data (req_time_ms),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign busy    = (state_ff != IDLE);
   assign accept  = start && !busy;
   assign id_ok   = ({1'b0, req_task_id} < hbw_pkg::TASK_LIMIT);
   assign req_idx = req_task_id[hbw_pkg::TASK_IDX_W-1:0];
   // wrapping distance since the last register or heartbeat
   assign elapsed = now_ff - ram_rd_data;
   assign hit     = cmp_valid_ff && registered_ff[cmp_idx_ff] && !timed_out_ff[cmp_idx_ff]
                    && (elapsed > timeout_ff);

   always_comb begin
      state_in      = state_ff;
      timeout_in    = csr_wr_en ? csr_wr_data : timeout_ff;
      now_in        = now_ff;
      registered_in = registered_ff;
      timed_out_in  = timed_out_ff;
      idx_in        = idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      cmp_valid_in  = 1'b0;
      any_in        = any_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      event_in      = event_ff;
      recov_in      = 1'b0;
      rsp_valid_in  = 1'b0;
      ram_we        = 1'b0;

      // compare stage, in the cycle after the ram read address is presented
      if (hit) begin
         timed_out_in[cmp_idx_ff] = 1'b1;
         last_in                  = hbw_pkg::CHAN_W'(cmp_idx_ff);
         count_in                 = count_ff + 1'b1;
         event_in                 = 1'b1;
      end

      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               event_in     = 1'b0;
               rsp_valid_in = 1'b1;
               priority if (req_operation == hbw_pkg::OP_REGISTER) begin
                  if (id_ok) begin
                     ram_we                 = 1'b1;
                     registered_in[req_idx] = 1'b1;
                     timed_out_in[req_idx]  = 1'b0;
                  end
               end else if (req_operation == hbw_pkg::OP_HEARTBEAT) begin
                  if (id_ok) begin
                     ram_we = 1'b1;
                     if (timed_out_ff[req_idx]) begin
                        timed_out_in[req_idx] = 1'b0;
                        recov_in              = 1'b1;
                     end
                  end
               end else if (req_operation == hbw_pkg::OP_CHECK) begin
                  rsp_valid_in = 1'b0;
                  now_in       = req_time_ms;
                  idx_in       = '0;
                  state_in     = SCAN;
               end else begin
                  // unknown opcode reports status only
                  rsp_valid_in = 1'b1;
               end
            end
         end
         SCAN: begin
            cmp_valid_in = 1'b1;
            cmp_idx_in   = idx_ff;
            idx_in       = idx_ff + 1'b1;
            if (idx_ff == hbw_pkg::LAST_TASK) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            any_in       = |timed_out_in;
            rsp_valid_in = 1'b1;
            state_in     = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         timeout_ff    <= hbw_pkg::TIMEOUT_RESET;
         registered_ff <= '0;
         timed_out_ff  <= '0;
         idx_ff        <= '0;
         cmp_valid_ff  <= 1'b0;
         any_ff        <= 1'b0;
         last_ff       <= '0;
         count_ff      <= '0;
         event_ff      <= 1'b0;
         recov_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         timeout_ff    <= timeout_in;
         registered_ff <= registered_in;
         timed_out_ff  <= timed_out_in;
         idx_ff        <= idx_in;
         cmp_valid_ff  <= cmp_valid_in;
         any_ff        <= any_in;
         last_ff       <= last_in;
         count_ff      <= count_in;
         event_ff      <= event_in;
         recov_ff      <= recov_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      now_ff     <= now_in;
      cmp_idx_ff <= cmp_idx_in;
   end

   // only channels below eight appear in the mask
   always_comb begin
      rsp_timed_out_mask = '0;
      for (int i = 0; i < hbw_pkg::MASK_W; i++) begin
         if (i < hbw_pkg::NUM_TASKS) begin
            rsp_timed_out_mask[i] = timed_out_ff[i];
         end
      end
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_any_timed_out          = any_ff;
   assign rsp_last_timed_out_channel = last_ff;
   assign rsp_total_timeouts         = count_ff;
   assign rsp_timeout_event          = event_ff;
   assign rsp_recovered              = recov_ff;

`ifndef NO_ASSERTIONS
   a_rsp_only_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == IDLE))
      else $error("result strobe while a check is running");

   a_ram_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == IDLE))
      else $error("timestamp write during a scan");

   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> (state_ff == SCAN || state_ff == DRAIN))
      else $error("compare stage active outside a scan");

   a_event_sets_any: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && event_ff) |-> any_ff)
      else $error("timeout event without aggregate flag");

   a_count_on_hit: assert property (@(posedge clock) disable iff (reset)
      hit |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("timeout counter missed a detection");
`endif

endmodule

// File: tb/hbw_checker.sv
// request/result monitor for the heartbeat watchdog: keeps its own copy of the channel
// table, predicts the status of every accepted request and compares it with the result
// depends on hbw_pkg
module hbw_checker
   import hbw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [1:0]          req_operation,
   input  logic [ID_W-1:0]     req_task_id,
   input  logic [TIME_W-1:0]   req_time_ms,
   input  logic                csr_wr_en,
   input  logic [TIME_W-1:0]   csr_wr_data,
   input  logic                rsp_valid,
   input  logic [MASK_W-1:0]   rsp_timed_out_mask,
   input  logic                rsp_any_timed_out,
   input  logic [CHAN_W-1:0]   rsp_last_timed_out_channel,
   input  logic [TIME_W-1:0]   rsp_total_timeouts,
   input  logic                rsp_timeout_event,
   input  logic                rsp_recovered,
   output int                  fail_count,
   output int                  pending_count
);

   typedef struct {
      logic [MASK_W-1:0] timed_out_mask;
      logic              any_timed_out;
      logic [CHAN_W-1:0] last_channel;
      logic [TIME_W-1:0] total_timeouts;
      logic              hung_event;
      logic              recovered;
   } watchdog_status_type;

   logic [TIME_W-1:0]  timeout_ms;
   logic [TIME_W-1:0]  seen_ms [NUM_TASKS];
   logic [NUM_TASKS-1:0] registered;
   logic [NUM_TASKS-1:0] hung;
   logic               any_hung;
   logic [CHAN_W-1:0]  last_hung;
   logic [TIME_W-1:0]  hung_total;
   watchdog_status_type expected_status [$];

   function automatic watchdog_status_type watchdog_step(input logic [1:0] op,
                                                         input logic [ID_W-1:0] id,
                                                         input logic [TIME_W-1:0] t);
      watchdog_status_type s;
      logic [TIME_W-1:0] elapsed;
      logic [TASK_IDX_W-1:0] idx;
      s.hung_event = 1'b0;
      s.recovered = 1'b0;
      idx = id[TASK_IDX_W-1:0];
      case (op)
         OP_REGISTER: begin
            if (id < NUM_TASKS) begin
               seen_ms[idx] = t;
               registered[idx] = 1'b1;
               hung[idx] = 1'b0;
            end
         end
         OP_HEARTBEAT: begin
            // last-seen moves even for a channel that was never registered
            if (id < NUM_TASKS) begin
               seen_ms[idx] = t;
               if (hung[idx]) begin
                  hung[idx] = 1'b0;
                  s.recovered = 1'b1;
               end
            end
         end
         OP_CHECK: begin
            for (int i = 0; i < NUM_TASKS; i++) begin
               if (registered[i] && !hung[i]) begin
                  elapsed = t - seen_ms[i];
                  if (elapsed > timeout_ms) begin
                     hung[i] = 1'b1;
                     last_hung = CHAN_W'(i);
                     hung_total = hung_total + 1'b1;
                     s.hung_event = 1'b1;
                  end
               end
            end
            // the aggregate flag only follows the table at a check
            any_hung = |hung;
         end
         default: ;
      endcase
      s.timed_out_mask = '0;
      for (int i = 0; i < NUM_TASKS && i < MASK_W; i++) s.timed_out_mask[i] = hung[i];
      s.any_timed_out = any_hung;
      s.last_channel = last_hung;
      s.total_timeouts = hung_total;
      return s;
   endfunction

   task automatic compare_field(input string name, input logic [TIME_W-1:0] want,
                                input logic [TIME_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      watchdog_status_type want;
      if (reset) begin
         fail_count = 0;
         timeout_ms = TIMEOUT_RESET;
         registered = '0;
         hung = '0;
         any_hung = 1'b0;
         last_hung = '0;
         hung_total = '0;
         expected_status.delete();
      end else begin
         if (csr_wr_en) timeout_ms = csr_wr_data;
         if (rsp_valid) begin
            if (expected_status.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual mask %0h total %0h",
                        $time, rsp_timed_out_mask, rsp_total_timeouts);
            end else begin
               want = expected_status.pop_front();
               compare_field("timed_out_mask", TIME_W'(want.timed_out_mask),
                             TIME_W'(rsp_timed_out_mask));
               compare_field("any_timed_out", TIME_W'(want.any_timed_out),
                             TIME_W'(rsp_any_timed_out));
               compare_field("last_timed_out_channel", TIME_W'(want.last_channel),
                             TIME_W'(rsp_last_timed_out_channel));
               compare_field("total_timeouts", want.total_timeouts, rsp_total_timeouts);
               compare_field("timeout_event", TIME_W'(want.hung_event),
                             TIME_W'(rsp_timeout_event));
               compare_field("recovered", TIME_W'(want.recovered), TIME_W'(rsp_recovered));
            end
         end
         if (start && !busy)
            expected_status.push_back(watchdog_step(req_operation, req_task_id, req_time_ms));
      end
      pending_count = expected_status.size();
   end

endmodule

// File: tb/multi_task_heartbeat_watchdog_tb.sv
// top of the heartbeat watchdog testbench: clock, reset, request and csr stimulus, verdict
// depends on hbw_pkg, hbw_checker and multi_task_heartbeat_watchdog
module multi_task_heartbeat_watchdog_tb;
   import hbw_pkg::*;

   localparam int SETTLE_CYCLES = NUM_TASKS + 4;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_operation;
   logic [ID_W-1:0]     req_task_id;
   logic [TIME_W-1:0]   req_time_ms;
   logic                csr_wr_en;
   logic [TIME_W-1:0]   csr_wr_data;
   logic                rsp_valid;
   logic [MASK_W-1:0]   rsp_timed_out_mask;
   logic                rsp_any_timed_out;
   logic [CHAN_W-1:0]   rsp_last_timed_out_channel;
   logic [TIME_W-1:0]   rsp_total_timeouts;
   logic                rsp_timeout_event;
   logic                rsp_recovered;
   logic                taken;
   int                  fail_count;
   int                  pending_count;
   int                  idle_pct;
   logic [TIME_W-1:0]   now_ms;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   multi_task_heartbeat_watchdog dut (
      .clock                      (clock),
      .reset                      (reset),
      .start                      (start),
      .busy                       (busy),
      .req_operation              (req_operation),
      .req_task_id                (req_task_id),
      .req_time_ms                (req_time_ms),
      .csr_wr_en                  (csr_wr_en),
      .csr_wr_data                (csr_wr_data),
      .rsp_valid                  (rsp_valid),
      .rsp_timed_out_mask         (rsp_timed_out_mask),
      .rsp_any_timed_out          (rsp_any_timed_out),
      .rsp_last_timed_out_channel (rsp_last_timed_out_channel),
      .rsp_total_timeouts         (rsp_total_timeouts),
      .rsp_timeout_event          (rsp_timeout_event),
      .rsp_recovered              (rsp_recovered)
   );

   hbw_checker monitor (
      .clock                      (clock),
      .reset                      (reset),
      .start                      (start),
      .busy                       (busy),
      .req_operation              (req_operation),
      .req_task_id                (req_task_id),
      .req_time_ms                (req_time_ms),
      .csr_wr_en                  (csr_wr_en),
      .csr_wr_data                (csr_wr_data),
      .rsp_valid                  (rsp_valid),
      .rsp_timed_out_mask         (rsp_timed_out_mask),
      .rsp_any_timed_out          (rsp_any_timed_out),
      .rsp_last_timed_out_channel (rsp_last_timed_out_channel),
      .rsp_total_timeouts         (rsp_total_timeouts),
      .rsp_timeout_event          (rsp_timeout_event),
      .rsp_recovered              (rsp_recovered),
      .fail_count                 (fail_count),
      .pending_count              (pending_count)
   );

   // acceptance seen at the rising edge, read back at the following falling edge
   always @(posedge clock) taken <= start && !busy;

   task automatic send_request(input logic [1:0] op, input logic [ID_W-1:0] id,
                               input logic [TIME_W-1:0] t);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         req_operation = 2'($urandom);
         req_task_id = ID_W'($urandom);
         req_time_ms = $urandom;
         @(negedge clock);
      end
      start = 1'b1;
      req_operation = op;
      req_task_id = id;
      req_time_ms = t;
      @(negedge clock);
      while (!taken) @(negedge clock);
   endtask

   task automatic drain();
      start = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [TIME_W-1:0] value);
      drain();
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      csr_wr_data = $urandom;
   endtask

   // mostly well-formed traffic on a moving clock, with some stale stamps and noise
   task automatic random_request(input int unsigned step_max);
      int unsigned pick;
      logic [1:0] op;
      logic [ID_W-1:0] id;
      logic [TIME_W-1:0] t;
      pick = $urandom_range(99);
      if ($urandom_range(19) == 0) now_ms = now_ms + $urandom;
      else now_ms = now_ms + $urandom_range(step_max);
      id = ID_W'($urandom_range(NUM_TASKS - 1));
      t = now_ms;
      if (pick < 40) begin
         op = OP_HEARTBEAT;
      end else if (pick < 55) begin
         op = OP_REGISTER;
      end else if (pick < 80) begin
         op = OP_CHECK;
         id = ID_W'($urandom);
      end else if (pick < 88) begin
         op = 2'($urandom_range(1));
         id = ID_W'($urandom_range(15, NUM_TASKS));
      end else if (pick < 93) begin
         op = OP_UNUSED;
         id = ID_W'($urandom);
         t = $urandom;
      end else begin
         op = OP_HEARTBEAT;
         t = now_ms - $urandom_range(step_max);
      end
      send_request(op, id, t);
   endtask

   task automatic run_phase(input logic [TIME_W-1:0] tmo, input int unsigned step_max,
                            input int idle, input int count);
      write_timeout(tmo);
      idle_pct = idle;
      repeat (count) random_request(step_max);
   endtask

   initial begin
      logic [TIME_W-1:0] tmo;
      reset = 1'b1;
      start = 1'b0;
      req_operation = '0;
      req_task_id = '0;
      req_time_ms = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      idle_pct = 23;
      now_ms = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // directed part at the reset timeout
      send_request(OP_CHECK, 4'd0, 32'd0);
      send_request(OP_REGISTER, 4'd0, 32'd0);
      send_request(OP_REGISTER, 4'd7, 32'hFFFF_FFF0);
      send_request(OP_REGISTER, 4'd8, 32'd5);
      send_request(OP_REGISTER, 4'd15, 32'hFFFF_FFFF);
      send_request(OP_HEARTBEAT, 4'd3, 32'd123);
      // channel 7 wraps past the timeout, channel 0 sits exactly on it
      send_request(OP_CHECK, 4'd0, 32'd3000);
      send_request(OP_CHECK, 4'd0, 32'd3001);
      send_request(OP_HEARTBEAT, 4'd0, 32'd3002);
      send_request(OP_HEARTBEAT, 4'd0, 32'd3003);
      send_request(OP_HEARTBEAT, 4'd12, 32'd0);
      send_request(OP_UNUSED, 4'd0, 32'hFFFF_FFFF);
      send_request(OP_REGISTER, 4'd7, 32'd3005);
      send_request(OP_CHECK, 4'd0, 32'd3006);
      for (int i = 1; i < 7; i++) send_request(OP_REGISTER, ID_W'(i), 32'hFFFF_FFFF);
      send_request(OP_CHECK, 4'd0, 32'hFFFF_FFFF);
      send_request(OP_CHECK, 4'd15, 32'd3000);
      send_request(OP_HEARTBEAT, 4'd5, 32'd0);
      send_request(OP_UNUSED, 4'd15, 32'd0);

      tmo = TIME_W'($urandom_range(5000, 1));
      run_phase(TIMEOUT_RESET, 700, 23, 350);
      run_phase(32'd1, 2, 23, 300);
      run_phase(32'hFFFF_FFFF, 32'h4000_0000, 23, 200);
      run_phase(32'd100, 40, 0, 400);
      run_phase(tmo, tmo / 3 + 1, 23, 350);
      run_phase(32'h8000_0000, 32'h2000_0000, 23, 300);

      drain();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule

// File: filelist.f
design/hbw_pkg.sv
design/hbw_time_ram.sv
design/multi_task_heartbeat_watchdog.sv
tb/hbw_checker.sv
tb/multi_task_heartbeat_watchdog_tb.sv
